>>> src/cordic_sine_unit_defines.svh
// assertion macros for the cordic sine unit
`ifndef CORDIC_SINE_UNIT_DEFINES_SVH
`define CORDIC_SINE_UNIT_DEFINES_SVH

`ifndef SYNTH
// condition in the same cycle, checked outside reset
`define CS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// condition in the following cycle, checked outside reset
`define CS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CS_ASSERT_SAME(lbl, ante, cons, msg)
`define CS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> src/cs_pkg.sv
// shared types, constants and arctangent table for the cordic sine unit
`timescale 1ns / 1ps
package cs_pkg;

  localparam int ITERATIONS = 20;
  localparam int DATA_W     = 32;
  localparam int SHIFT_W    = 5;
  localparam int ATAN_DEPTH = 32;

  localparam logic [DATA_W-1:0] GAIN_START   = 32'h26DC_EDB0;
  localparam logic [DATA_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [DATA_W-1:0] HALF_TURN    = 32'h8000_0000;

  // arctangent of 2^-k, 2^32 per full turn
  localparam logic [DATA_W-1:0] ATAN_TABLE [ATAN_DEPTH] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
    32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
    32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
  };

  // rotation vector carried down the pipeline
  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
  } cs_vec_t;

  // angle lies in [-90, 90) degrees
  function automatic logic in_half_plane(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] sum;
    sum = v + QUARTER_TURN;
    return sum < HALF_TURN;
  endfunction

endpackage

>>> src/cs_rot_stage.sv
// one registered cordic rotation step with its valid bit
`timescale 1ns / 1ps
module cs_rot_stage import cs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [SHIFT_W-1:0] shift,
  input  logic [DATA_W-1:0]  atan,
  input  logic               valid_i,
  input  cs_vec_t            vec_i,
  output logic               valid_o,
  output cs_vec_t            vec_o
);

  cs_vec_t vec_next;

  // rotate towards zero residual angle
  always_comb begin
    logic [DATA_W-1:0] dx;
    logic [DATA_W-1:0] dy;
    dx = DATA_W'($signed(vec_i.y) >>> shift);
    dy = DATA_W'($signed(vec_i.x) >>> shift);
    if (!vec_i.z[DATA_W-1]) begin
      vec_next.x = vec_i.x - dx;
      vec_next.y = vec_i.y + dy;
      vec_next.z = vec_i.z - atan;
    end else begin
      vec_next.x = vec_i.x + dx;
      vec_next.y = vec_i.y - dy;
      vec_next.z = vec_i.z + atan;
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en && valid_i) begin
      vec_o <= vec_next;
    end
  end

endmodule

>>> src/cordic_sine_unit.sv
// cordic sine unit: reflection stage followed by one stage per rotation step
// throughput: one beat per cycle unless stalled; each stage holds one beat and moves on
// when the next stage is empty or moving, so bubbles close up under a stalled output
// reset: rst clears every stage valid bit; payload registers are not reset
`timescale 1ns / 1ps
`include "cordic_sine_unit_defines.svh"
module cordic_sine_unit import cs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [DATA_W-1:0] angle,
  input  logic              angle_valid,
  output logic              angle_stall,
  output logic [DATA_W-1:0] sine,
  output logic              sine_valid,
  input  logic              sine_stall
);

  logic               valid [ITERATIONS+1];
  cs_vec_t            vec   [ITERATIONS+1];
  logic               en    [ITERATIONS+1];
  cs_vec_t            vec0_next;

  // stage enables, from the output back to the input
  always_comb begin
    en[ITERATIONS] = !valid[ITERATIONS] || !sine_stall;
    for (int i = ITERATIONS - 1; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  assign angle_stall = !en[0];

  // reflect angles outside [-90, 90) onto 180 minus the angle
  always_comb begin
    vec0_next.x = GAIN_START;
    vec0_next.y = '0;
    vec0_next.z = in_half_plane(angle) ? angle : (HALF_TURN - angle);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en[0]) begin
      valid[0] <= angle_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && angle_valid) begin
      vec[0] <= vec0_next;
    end
  end

  // rotation stages
  for (genvar k = 0; k < ITERATIONS; k++) begin : g_rot
    cs_rot_stage u_stage (
      .clk     (clk),
      .rst     (rst),
      .en      (en[k+1]),
      .shift   (SHIFT_W'(k)),
      .atan    (ATAN_TABLE[k]),
      .valid_i (valid[k]),
      .vec_i   (vec[k]),
      .valid_o (valid[k+1]),
      .vec_o   (vec[k+1])
    );
  end

  assign sine       = vec[ITERATIONS].y;
  assign sine_valid = valid[ITERATIONS];

  // checks
  `CS_ASSERT_NEXT(a_capture, angle_valid && !angle_stall, valid[0], "accepted beat not captured")
  `CS_ASSERT_SAME(a_reflect, valid[0], (vec[0].z + QUARTER_TURN) <= HALF_TURN, "reflected angle out of range")
  `CS_ASSERT_SAME(a_stall_full, angle_stall, valid[0] && valid[ITERATIONS] && sine_stall, "input stalled with room in pipeline")

endmodule
